// ----- rtl/core/qmb_pkg.sv -----
// ----------------------------------------------------------------------------
// qmb_pkg
// Shared types and constants of the quartic Montgomery basemul pipeline.
// ----------------------------------------------------------------------------
package qmb_pkg;

   localparam int unsigned LANES  = 4;
   localparam int unsigned STAGES = 7;

   localparam logic [11:0] MOD_Q    = 12'd3457;
   localparam logic [13:0] MOD_QINV = 14'd12929;

   typedef logic [LANES-1:0][15:0] coef_vec_type;
   typedef logic [LANES-1:0][31:0] acc_vec_type;
   typedef logic [11:0]            twiddle_type;

endpackage

// ----- rtl/core/qmb_lambda_scale.sv -----
// ----------------------------------------------------------------------------
// qmb_lambda_scale
// Three-stage signed Montgomery multiply of each b coefficient by lambda.
// The a and b coefficients travel alongside the scaled b values.
// ----------------------------------------------------------------------------
module qmb_lambda_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qmb_pkg::coef_vec_type in_a,
   input  qmb_pkg::coef_vec_type in_b,
   input  qmb_pkg::twiddle_type  in_twiddle,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qmb_pkg::coef_vec_type out_a,
   output qmb_pkg::coef_vec_type out_b,
   output qmb_pkg::coef_vec_type out_lb
);
   import qmb_pkg::*;

   logic [2:0] valid_ff, valid_in, stage_rdy;

   coef_vec_type                 a0_ff, b0_ff, a1_ff, b1_ff, a2_ff, b2_ff;
   logic [15:0]                  fq0_ff, fq0_in;
   logic [LANES-1:0][11:0]       hf0_ff, hf0_in, hf1_ff;
   coef_vec_type                 lo1_ff, lo1_in;
   coef_vec_type                 lb2_ff, lb2_in;
   logic signed [27:0]           bt [LANES];
   logic signed [28:0]           lq [LANES];
   logic [12:0]                  hq [LANES];

   // stage handshake
   always_comb begin
      stage_rdy[2] = !valid_ff[2] || out_ready;
      stage_rdy[1] = !valid_ff[1] || stage_rdy[2];
      stage_rdy[0] = !valid_ff[0] || stage_rdy[1];
      valid_in[0]  = stage_rdy[0] ? in_valid    : valid_ff[0];
      valid_in[1]  = stage_rdy[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2]  = stage_rdy[2] ? valid_ff[1] : valid_ff[2];
   end

   // lambda times qinv, and high half of b times lambda
   always_comb begin
      fq0_in = 16'({{4{in_twiddle[11]}}, in_twiddle} * {2'b00, MOD_QINV});
      for (int l = 0; l < LANES; l++) begin
         bt[l]     = $signed(in_b[l]) * $signed(in_twiddle);
         hf0_in[l] = bt[l][27:16];
      end
   end

   // low factor times b
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lo1_in[l] = 16'(b0_ff[l] * fq0_ff);
      end
   end

   // high half of low times q, then difference
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lq[l]     = $signed(lo1_ff[l]) * $signed({1'b0, MOD_Q});
         hq[l]     = lq[l][28:16];
         lb2_in[l] = {{4{hf1_ff[l][11]}}, hf1_ff[l]} - {{3{hq[l][12]}}, hq[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         a0_ff  <= in_a;
         b0_ff  <= in_b;
         fq0_ff <= fq0_in;
         hf0_ff <= hf0_in;
      end
      if (stage_rdy[1]) begin
         a1_ff  <= a0_ff;
         b1_ff  <= b0_ff;
         hf1_ff <= hf0_ff;
         lo1_ff <= lo1_in;
      end
      if (stage_rdy[2]) begin
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         lb2_ff <= lb2_in;
      end
   end

   assign in_ready  = stage_rdy[0];
   assign out_valid = valid_ff[2];
   assign out_a     = a2_ff;
   assign out_b     = b2_ff;
   assign out_lb    = lb2_ff;

endmodule

// ----- rtl/core/qmb_convolve.sv -----
// ----------------------------------------------------------------------------
// qmb_convolve
// Negacyclic-style convolution modulo x^4 - lambda: sixteen registered
// products, then four wrapping 32-bit sums.
// ----------------------------------------------------------------------------
module qmb_convolve (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  qmb_pkg::coef_vec_type in_a,
   input  qmb_pkg::coef_vec_type in_b,
   input  qmb_pkg::coef_vec_type in_lb,
   output logic                  out_valid,
   input  logic                  out_ready,
   output qmb_pkg::acc_vec_type  out_acc
);
   import qmb_pkg::*;

   logic [1:0] valid_ff, valid_in, stage_rdy;

   logic signed [31:0] prod_in [LANES][LANES];
   logic        [31:0] prod_ff [LANES][LANES];
   acc_vec_type        acc_ff, acc_in;
   logic        [15:0] bv;

   always_comb begin
      stage_rdy[1] = !valid_ff[1] || out_ready;
      stage_rdy[0] = !valid_ff[0] || stage_rdy[1];
      valid_in[0]  = stage_rdy[0] ? in_valid    : valid_ff[0];
      valid_in[1]  = stage_rdy[1] ? valid_ff[0] : valid_ff[1];
   end

   // wrapped terms use lambda-scaled b
   always_comb begin
      bv = '0;
      for (int k = 0; k < LANES; k++) begin
         for (int i = 0; i < LANES; i++) begin
            bv            = (i <= k) ? in_b[2'(k - i)] : in_lb[2'(k - i)];
            prod_in[k][i] = $signed(in_a[i]) * $signed(bv);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         acc_in[k] = prod_ff[k][0] + prod_ff[k][1] + prod_ff[k][2] + prod_ff[k][3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         for (int k = 0; k < LANES; k++) begin
            for (int i = 0; i < LANES; i++) begin
               prod_ff[k][i] <= prod_in[k][i];
            end
         end
      end
      if (stage_rdy[1]) begin
         acc_ff <= acc_in;
      end
   end

   assign in_ready  = stage_rdy[0];
   assign out_valid = valid_ff[1];
   assign out_acc   = acc_ff;

endmodule

// ----- rtl/core/qmb_reduce.sv -----
// ----------------------------------------------------------------------------
// qmb_reduce
// Two-stage Montgomery reduction of each 32-bit sum using its unsigned low
// word; the last stage is the result register.
// ----------------------------------------------------------------------------
module qmb_reduce (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  qmb_pkg::acc_vec_type  in_acc,
   output logic                  out_valid,
   input  logic                  out_ready,
   output qmb_pkg::coef_vec_type out_coef
);
   import qmb_pkg::*;

   logic [1:0] valid_ff, valid_in, stage_rdy;

   coef_vec_type  m_ff, m_in, hi_ff, res_ff, res_in;
   logic [27:0]   mq [LANES];

   always_comb begin
      stage_rdy[1] = !valid_ff[1] || out_ready;
      stage_rdy[0] = !valid_ff[0] || stage_rdy[1];
      valid_in[0]  = stage_rdy[0] ? in_valid    : valid_ff[0];
      valid_in[1]  = stage_rdy[1] ? valid_ff[0] : valid_ff[1];
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         m_in[l]   = 16'(in_acc[l][15:0] * {2'b00, MOD_QINV});
         mq[l]     = m_ff[l] * MOD_Q;
         res_in[l] = hi_ff[l] - {4'b0000, mq[l][27:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         m_ff <= m_in;
         for (int l = 0; l < LANES; l++) begin
            hi_ff[l] <= in_acc[l][31:16];
         end
      end
      if (stage_rdy[1]) begin
         res_ff <= res_in;
      end
   end

   assign in_ready  = stage_rdy[0];
   assign out_valid = valid_ff[1];
   assign out_coef  = res_ff;

endmodule

// ----- rtl/core/quartic_montgomery_basemul.sv -----
// ----------------------------------------------------------------------------
// quartic_montgomery_basemul
// Degree-3 polynomial product modulo x^4 - lambda, Montgomery arithmetic, q 3457.
// pipeline: 7 register stages; the result is shown from the last one
// throughput: one item per cycle while the output is not stalled, set by the seven-stage pipeline
// a stalled result holds the output register; empty stages keep filling
// reset clears all stage valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module quartic_montgomery_basemul (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_a_coef0,
   input  logic signed [15:0] req_a_coef1,
   input  logic signed [15:0] req_a_coef2,
   input  logic signed [15:0] req_a_coef3,
   input  logic signed [15:0] req_b_coef0,
   input  logic signed [15:0] req_b_coef1,
   input  logic signed [15:0] req_b_coef2,
   input  logic signed [15:0] req_b_coef3,
   input  logic signed [11:0] req_twiddle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_prod_coef0,
   output logic signed [15:0] rsp_prod_coef1,
   output logic signed [15:0] rsp_prod_coef2,
   output logic signed [15:0] rsp_prod_coef3
);
   import qmb_pkg::*;

   coef_vec_type req_a, req_b, sc_a, sc_b, sc_lb, prod;
   acc_vec_type  cv_acc;
   logic         sc_valid, sc_ready, cv_valid, cv_ready;
   logic [3:0]   inflight_ff, inflight_in;

   assign req_a = {req_a_coef3, req_a_coef2, req_a_coef1, req_a_coef0};
   assign req_b = {req_b_coef3, req_b_coef2, req_b_coef1, req_b_coef0};

   qmb_lambda_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_a       (req_a),
      .in_b       (req_b),
      .in_twiddle (req_twiddle),
      .out_valid  (sc_valid),
      .out_ready  (sc_ready),
      .out_a      (sc_a),
      .out_b      (sc_b),
      .out_lb     (sc_lb)
   );

   qmb_convolve u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sc_valid),
      .in_ready  (sc_ready),
      .in_a      (sc_a),
      .in_b      (sc_b),
      .in_lb     (sc_lb),
      .out_valid (cv_valid),
      .out_ready (cv_ready),
      .out_acc   (cv_acc)
   );

   qmb_reduce u_redc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cv_valid),
      .in_ready  (cv_ready),
      .in_acc    (cv_acc),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_coef  (prod)
   );

   assign rsp_prod_coef0 = prod[0];
   assign rsp_prod_coef1 = prod[1];
   assign rsp_prod_coef2 = prod[2];
   assign rsp_prod_coef3 = prod[3];

   // items in flight, for checking
   assign inflight_in = inflight_ff + 4'(req_valid && req_ready)
                                    - 4'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_full_only_when_stalled : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while output is free");

   a_inflight_bound : assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 4'(STAGES))
      else $error("more items in flight than pipeline stages");

   a_no_result_when_empty : assert property (@(posedge clock) disable iff (reset)
      inflight_ff == '0 |-> !rsp_valid)
      else $error("result shown with no item in flight");

   a_full_blocks_input : assert property (@(posedge clock) disable iff (reset)
      inflight_ff == 4'(STAGES) |-> !req_ready || rsp_ready)
      else $error("full pipeline accepting without drain");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quartic Montgomery basemul pipeline. Operand
// items go in over a valid/ready channel, an independent model of the ring
// product predicts each result, and every result item is checked field by
// field in order. Runs directed corner items and then random traffic under
// several sender and receiver idling mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import qmb_pkg::*;

   localparam int MODULUS      = MOD_Q;
   localparam int MONT_QINV    = MOD_QINV;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_LIMIT   = 4000;
   localparam int MAX_REPORTS  = 40;

   typedef struct {
      coef_vec_type a;
      coef_vec_type b;
      twiddle_type  twiddle;
   } operands_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_a_coef0 = '0;
   logic signed [15:0] req_a_coef1 = '0;
   logic signed [15:0] req_a_coef2 = '0;
   logic signed [15:0] req_a_coef3 = '0;
   logic signed [15:0] req_b_coef0 = '0;
   logic signed [15:0] req_b_coef1 = '0;
   logic signed [15:0] req_b_coef2 = '0;
   logic signed [15:0] req_b_coef3 = '0;
   logic signed [11:0] req_twiddle = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_prod_coef0;
   logic signed [15:0] rsp_prod_coef1;
   logic signed [15:0] rsp_prod_coef2;
   logic signed [15:0] rsp_prod_coef3;

   coef_vec_type pending_products[$];
   int           mismatches   = 0;
   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   int           hold_off_left = 0;
   int           quiet_cycles  = 0;

   quartic_montgomery_basemul i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_a_coef0    (req_a_coef0),
      .req_a_coef1    (req_a_coef1),
      .req_a_coef2    (req_a_coef2),
      .req_a_coef3    (req_a_coef3),
      .req_b_coef0    (req_b_coef0),
      .req_b_coef1    (req_b_coef1),
      .req_b_coef2    (req_b_coef2),
      .req_b_coef3    (req_b_coef3),
      .req_twiddle    (req_twiddle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_prod_coef0 (rsp_prod_coef0),
      .rsp_prod_coef1 (rsp_prod_coef1),
      .rsp_prod_coef2 (rsp_prod_coef2),
      .rsp_prod_coef3 (rsp_prod_coef3)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // signed montgomery multiply of a b coefficient by lambda
   function automatic int twist_by_lambda(int v, int lam);
      logic [31:0] t;
      int          fq;
      int          lo;
      int          hf;
      int          hq;
      t  = lam * MONT_QINV;
      fq = $signed(t[15:0]);
      t  = v * fq;
      lo = $signed(t[15:0]);
      hf = (v * lam) >>> 16;
      hq = (lo * MODULUS) >>> 16;
      t  = hf - hq;
      return $signed(t[15:0]);
   endfunction

   function automatic logic [15:0] mont_reduce(logic [31:0] acc);
      logic [31:0] m;
      logic [31:0] hq;
      logic [31:0] t;
      m  = (acc * MONT_QINV) & 32'h0000_ffff;
      hq = (m * MODULUS) >> 16;
      t  = (acc >> 16) - hq;
      return t[15:0];
   endfunction

   function automatic coef_vec_type ring_product(operands_type op);
      int           av[4];
      int           bv[4];
      int           tw[4];
      int           lam;
      logic [31:0]  acc;
      coef_vec_type res;
      lam = $signed(op.twiddle);
      for (int i = 0; i < 4; i++) begin
         av[i] = $signed(op.a[i]);
         bv[i] = $signed(op.b[i]);
         tw[i] = twist_by_lambda(bv[i], lam);
      end
      for (int k = 0; k < 4; k++) begin
         acc = '0;
         for (int i = 0; i < 4; i++) begin
            if (i <= k) begin
               acc += av[i] * bv[(k - i) & 3];
            end else begin
               acc += av[i] * tw[(k - i) & 3];
            end
         end
         res[k] = mont_reduce(acc);
      end
      return res;
   endfunction

   function automatic operands_type pack_operands(
      int a0, int a1, int a2, int a3, int b0, int b1, int b2, int b3, int lam);
      operands_type op;
      op.a       = {a3[15:0], a2[15:0], a1[15:0], a0[15:0]};
      op.b       = {b3[15:0], b2[15:0], b1[15:0], b0[15:0]};
      op.twiddle = lam[11:0];
      return op;
   endfunction

   function automatic logic [15:0] random_coef();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'h0001;
         endcase
      end else if (sel <= 2) begin
         return 16'($urandom_range(0, 2 * MODULUS) - MODULUS);
      end
      return 16'($urandom);
   endfunction

   function automatic operands_type random_operands();
      operands_type op;
      for (int i = 0; i < 4; i++) begin
         op.a[i] = random_coef();
         op.b[i] = random_coef();
      end
      if ($urandom_range(0, 99) < 85) begin
         op.twiddle = 12'($urandom_range(0, 3456) - 1728);
      end else begin
         op.twiddle = 12'($urandom);
      end
      return op;
   endfunction

   task automatic send_item(operands_type op);
      int gap;
      req_a_coef0 <= op.a[0];
      req_a_coef1 <= op.a[1];
      req_a_coef2 <= op.a[2];
      req_a_coef3 <= op.a[3];
      req_b_coef0 <= op.b[0];
      req_b_coef1 <= op.b[1];
      req_b_coef2 <= op.b[2];
      req_b_coef3 <= op.b[3];
      req_twiddle <= op.twiddle;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_products.push_back(ring_product(op));
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) send_item(random_operands());
   endtask

   task automatic test_corner_items();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_item(pack_operands(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(pack_operands(1, 0, 0, 0, 1234, -567, 89, -3456, 1000));
      send_item(pack_operands(0, 0, 0, 1, 0, 0, 0, 1, 1728));
      send_item(pack_operands(32767, 32767, 32767, 32767,
                              32767, 32767, 32767, 32767, 1728));
      send_item(pack_operands(-32768, -32768, -32768, -32768,
                              -32768, -32768, -32768, -32768, -1728));
      send_item(pack_operands(32767, 32767, 32767, 32767,
                              -32768, -32768, -32768, -32768, 2047));
      send_item(pack_operands(-32768, -32768, -32768, -32768,
                              32767, 32767, 32767, 32767, -2048));
      send_item(pack_operands(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                              16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 12'h555));
      send_item(pack_operands(16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                              16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 12'haaa));
      send_item(pack_operands(-1, -1, -1, -1, -1, -1, -1, -1, -1));
      send_item(pack_operands(3457, -3457, 6914, -6914, 3457, 3457, -3457, 1, 1));
      send_item(pack_operands(1, 1, 1, 1, 1, 1, 1, 1, -1));
      send_item(pack_operands(-32768, 0, 0, -32768, -32768, 0, 0, -32768, 2047));
      send_item(pack_operands(32767, -32768, 32767, -32768,
                              32767, -32768, 32767, -32768, -2048));
      send_item(pack_operands(0, 0, 0, 0, 32767, -32768, 12345, -1, 1728));
      send_item(pack_operands(12345, -23456, 54, -7, 0, 0, 0, 0, -1728));
   endtask

   task automatic test_streaming();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_random(300);
   endtask

   task automatic test_sparse_sender();
      send_idle_pct = 83;
      stall_pct     = 0;
      send_random(250);
   endtask

   task automatic test_stalling_receiver();
      send_idle_pct = 0;
      stall_pct     = 83;
      send_random(250);
   endtask

   task automatic test_mixed_idling();
      send_idle_pct = 6;
      stall_pct     = 6;
      send_random(250);
   endtask

   task automatic test_pipeline_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_left = 400;
      send_random(200);
   endtask

   // receiver side, including the long hold-off
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      coef_vec_type got;
      coef_vec_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_prod_coef3, rsp_prod_coef2, rsp_prod_coef1, rsp_prod_coef0};
            if (pending_products.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: unexpected result item, expected none, actual %h",
                           $time, got);
               end
            end else begin
               want = pending_products.pop_front();
               for (int k = 0; k < 4; k++) begin
                  if (got[k] !== want[k]) begin
                     mismatches++;
                     if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: prod_coef%0d mismatch, expected %0d, actual %0d",
                                 $time, k, $signed(want[k]), $signed(got[k]));
                     end
                  end
               end
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_items();
      test_streaming();
      test_sparse_sender();
      test_stalling_receiver();
      test_mixed_idling();
      test_pipeline_backpressure();
      req_valid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/qmb_pkg.sv
rtl/core/qmb_lambda_scale.sv
rtl/core/qmb_convolve.sv
rtl/core/qmb_reduce.sv
rtl/core/quartic_montgomery_basemul.sv
test/tb_top.sv
